### hw/rtl/pfdf_pkg.sv
package pfdf_pkg;

    localparam int MAX_SIDE = 256;
    localparam int SIDE_W   = $clog2(MAX_SIDE + 1);
    localparam int COORD_W  = $clog2(MAX_SIDE);
    localparam int ADDR_W   = 2 * COORD_W;
    localparam int CNT_W    = ADDR_W + 1;
    localparam int CELLS    = MAX_SIDE * MAX_SIDE;
    localparam int H_W      = 32;
    localparam int EPS_W    = 31;

    localparam logic [1:0] KIND_WRITE = 2'd0;
    localparam logic [1:0] KIND_RUN   = 2'd1;
    localparam logic [1:0] KIND_READ  = 2'd2;

    localparam logic [1:0] REG_SIDE = 2'd0;
    localparam logic [1:0] REG_SEA  = 2'd1;
    localparam logic [1:0] REG_EPS  = 2'd2;

    // Heap entry: ordering is (key, row, col), which equals (key, raster index).
    typedef struct packed {
        logic signed [H_W-1:0]     key;
        logic        [COORD_W-1:0] row;
        logic        [COORD_W-1:0] col;
    } heap_entry_t;

    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] waddr;
        heap_entry_t       wdata;
        logic [ADDR_W-1:0] raddr_a;
        logic [ADDR_W-1:0] raddr_b;
    } heap_req_t;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_RD_OUT,
        ST_RUN_OUT,
        ST_SEED_RD,
        ST_SEED_CHK,
        ST_SEED_NEXT,
        ST_PUSH_START,
        ST_PUSH_RD,
        ST_PUSH_CMP,
        ST_POP_START,
        ST_POP_TAKE,
        ST_SIFT_RD,
        ST_SIFT_CMP,
        ST_NB_ADDR,
        ST_NB_MUL,
        ST_NB_RD,
        ST_NB_CHK,
        ST_NB_NEXT
    } state_t;

    function automatic logic heap_less(heap_entry_t a, heap_entry_t b);
        logic res;
        if (a.key != b.key)
        begin
            res = ($signed(a.key) < $signed(b.key));
        end
        else
        begin
            res = ({a.row, a.col} < {b.row, b.col});
        end
        return res;
    endfunction

endpackage

### hw/rtl/pfdf_heap.sv
module pfdf_heap
    import pfdf_pkg::*;
(
    input  logic        clk,
    input  heap_req_t   req,
    output heap_entry_t rdata_a,
    output heap_entry_t rdata_b
);

    // Priority queue storage: one write port, two registered read ports.
    heap_entry_t mem [CELLS];

    always_ff @(posedge clk)
    begin
        if (req.we)
        begin
            mem[req.waddr] <= req.wdata;
        end
        rdata_a <= mem[req.raddr_a];
        rdata_b <= mem[req.raddr_b];
    end

endmodule

### hw/rtl/priority_flood_depression_fill.sv
// Height writes are taken one word per cycle while idle and give no result. A read waits
// for a free result slot, registers its word and returns to idle. A run scans each cell
// (read, check, next) to seed, then pops cells (start, take); a neighbor passes address,
// multiply and next, one in the grid also read and check. A push adds start plus read and
// compare per level climbed, a sift read and compare per level descended. Reset clears
// control state, restores grid_side 256, sea_level 0, fill_epsilon 0; memories stay as is.
module priority_flood_depression_fill
    import pfdf_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [1:0]         kind,
    input  logic [15:0]        cell_index,
    input  logic signed [31:0] height_in,
    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [31:0] filled_height,
    output logic [15:0]        result_index,
    output logic               run_done,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [1:0]         cfg_index,
    input  logic [31:0]        cfg_data
);

    // Configuration registers. The cell count is kept alongside the side so that
    // range checks on an index need only a compare.
    logic [SIDE_W-1:0]     side_reg;
    logic [CNT_W-1:0]      cells_reg;
    logic signed [H_W-1:0] sea_reg;
    logic [EPS_W-1:0]      eps_reg;
    logic [SIDE_W-1:0]     side_clamp;

    assign cfg_ready = 1'b1;

    always_comb
    begin
        side_clamp = cfg_data[SIDE_W-1:0];
        if (side_clamp < SIDE_W'(3))
        begin
            side_clamp = SIDE_W'(3);
        end
        else if (side_clamp > SIDE_W'(MAX_SIDE))
        begin
            side_clamp = SIDE_W'(MAX_SIDE);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            side_reg  <= SIDE_W'(MAX_SIDE);
            cells_reg <= CNT_W'(CELLS);
            sea_reg   <= '0;
            eps_reg   <= '0;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_SIDE:
                begin
                    side_reg  <= side_clamp;
                    cells_reg <= CNT_W'(side_clamp * side_clamp);
                end
                REG_SEA: sea_reg <= cfg_data;
                REG_EPS: eps_reg <= cfg_data[EPS_W-1:0];
                default: ;
            endcase
        end
    end

    // Cell memories. Terrain height and filled height are 32-bit words; the visited
    // map is one bit a cell and is rewritten for every grid cell by the seeding scan,
    // so no separate clearing pass is needed.
    logic signed [H_W-1:0] height_mem [CELLS];
    logic signed [H_W-1:0] filled_mem [CELLS];
    logic                  visited_mem [CELLS];

    logic                  h_we;
    logic [ADDR_W-1:0]     h_waddr;
    logic signed [H_W-1:0] h_wdata;
    logic [ADDR_W-1:0]     cell_raddr;
    logic signed [H_W-1:0] h_rdata;
    logic                  f_we;
    logic [ADDR_W-1:0]     cw_addr;
    logic signed [H_W-1:0] f_wdata;
    logic [ADDR_W-1:0]     f_raddr;
    logic signed [H_W-1:0] f_rdata;
    logic                  v_we;
    logic                  v_wdata;
    logic                  v_rdata;

    always_ff @(posedge clk)
    begin
        if (h_we)
        begin
            height_mem[h_waddr] <= h_wdata;
        end
        h_rdata <= height_mem[cell_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (f_we)
        begin
            filled_mem[cw_addr] <= f_wdata;
        end
        f_rdata <= filled_mem[f_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (v_we)
        begin
            visited_mem[cw_addr] <= v_wdata;
        end
        v_rdata <= visited_mem[cell_raddr];
    end

    // Priority queue.
    heap_req_t   hreq;
    heap_entry_t hrd_a;
    heap_entry_t hrd_b;

    pfdf_heap u_heap (
        .clk     (clk),
        .req     (hreq),
        .rdata_a (hrd_a),
        .rdata_b (hrd_b)
    );

    // Sequencer state.
    state_t state_reg, state_next;
    state_t ret_reg, ret_next;
    logic [CNT_W-1:0]      count_reg, count_next;
    logic [CNT_W-1:0]      pos_reg, pos_next;
    heap_entry_t           item_reg, item_next;
    heap_entry_t           top_reg, top_next;
    logic signed [H_W-1:0] raised_reg, raised_next;
    logic [COORD_W-1:0]    srow_reg, srow_next;
    logic [COORD_W-1:0]    scol_reg, scol_next;
    logic [ADDR_W-1:0]     saddr_reg, saddr_next;
    logic [2:0]            nb_reg, nb_next;
    logic [COORD_W-1:0]    px_reg, px_next;
    logic [COORD_W-1:0]    pz_reg, pz_next;
    logic                  inb_reg, inb_next;
    logic [ADDR_W-1:0]     naddr_reg, naddr_next;
    logic [15:0]           rd_idx_reg, rd_idx_next;
    logic                  rd_ok_reg, rd_ok_next;

    // Result word register.
    logic                  out_valid_reg, out_valid_next;
    logic signed [H_W-1:0] out_h_reg, out_h_next;
    logic [15:0]           out_idx_reg, out_idx_next;
    logic                  out_done_reg, out_done_next;

    logic in_accept;
    logic slot_free;

    assign in_stall      = (state_reg != ST_IDLE);
    assign in_accept     = in_valid && !in_stall;
    assign slot_free     = !out_valid_reg || !out_stall;
    assign out_valid     = out_valid_reg;
    assign filled_height = out_h_reg;
    assign result_index  = out_idx_reg;
    assign run_done      = out_done_reg;

    // Shared conditions.
    logic [SIDE_W-1:0]       side_m1;
    logic                    idx_ok;
    logic                    scan_last;
    logic                    seed_rim;
    logic                    is_seed;
    logic [CNT_W-1:0]        up_pos;
    logic [CNT_W:0]          lchild;
    logic [CNT_W:0]          rchild;
    logic                    l_none;
    logic                    r_ok;
    logic                    take_r;
    heap_entry_t             child;
    logic [ADDR_W-1:0]       child_addr;
    logic                    push_up;
    logic                    sift_down;
    logic signed [H_W:0]     raise_sum;
    logic signed [H_W-1:0]   nb_fill;
    logic signed [1:0]       dx;
    logic signed [1:0]       dz;
    logic signed [COORD_W+1:0] px_s;
    logic signed [COORD_W+1:0] pz_s;

    assign side_m1   = side_reg - SIDE_W'(1);
    assign idx_ok    = ({1'b0, cell_index} < cells_reg);
    assign scan_last = (SIDE_W'(srow_reg) == side_m1) && (SIDE_W'(scol_reg) == side_m1);
    assign seed_rim  = (srow_reg == '0) || (scol_reg == '0) ||
                       (SIDE_W'(srow_reg) == side_m1) || (SIDE_W'(scol_reg) == side_m1);
    assign is_seed   = seed_rim || (h_rdata <= sea_reg);

    assign up_pos    = (pos_reg - CNT_W'(1)) >> 1;
    assign lchild    = {pos_reg, 1'b1};
    assign rchild    = lchild + (CNT_W+1)'(1);
    assign l_none    = (lchild >= {1'b0, count_reg});
    assign r_ok      = (rchild < {1'b0, count_reg});
    assign take_r    = r_ok && heap_less(hrd_b, hrd_a);
    assign child     = take_r ? hrd_b : hrd_a;
    assign child_addr = take_r ? rchild[ADDR_W-1:0] : lchild[ADDR_W-1:0];
    assign push_up   = heap_less(item_reg, hrd_a);
    assign sift_down = heap_less(child, item_reg);

    // Popped level plus epsilon, saturating at the largest height.
    assign raise_sum = {hrd_a.key[H_W-1], hrd_a.key} + $signed({2'b00, eps_reg});
    assign nb_fill   = (h_rdata > raised_reg) ? h_rdata : raised_reg;

    // Neighbor offsets in raster order, center skipped.
    always_comb
    begin
        case (nb_reg)
            3'd0:    begin dz = -2'sd1; dx = -2'sd1; end
            3'd1:    begin dz = -2'sd1; dx =  2'sd0; end
            3'd2:    begin dz = -2'sd1; dx =  2'sd1; end
            3'd3:    begin dz =  2'sd0; dx = -2'sd1; end
            3'd4:    begin dz =  2'sd0; dx =  2'sd1; end
            3'd5:    begin dz =  2'sd1; dx = -2'sd1; end
            3'd6:    begin dz =  2'sd1; dx =  2'sd0; end
            default: begin dz =  2'sd1; dx =  2'sd1; end
        endcase
    end

    assign px_s = $signed({2'b00, top_reg.col}) + (COORD_W+2)'(dx);
    assign pz_s = $signed({2'b00, top_reg.row}) + (COORD_W+2)'(dz);

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    if (kind == KIND_READ)
                    begin
                        state_next = ST_RD_OUT;
                    end
                    else if (kind == KIND_RUN)
                    begin
                        state_next = ST_SEED_RD;
                    end
                end
            end
            ST_RD_OUT, ST_RUN_OUT:
            begin
                if (slot_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_SEED_RD:   state_next = ST_SEED_CHK;
            ST_SEED_CHK:  state_next = is_seed ? ST_PUSH_START : ST_SEED_NEXT;
            ST_SEED_NEXT: state_next = scan_last ? ST_POP_START : ST_SEED_RD;
            ST_PUSH_START:
            begin
                state_next = (count_reg >= CNT_W'(CELLS)) ? ret_reg : ST_PUSH_RD;
            end
            ST_PUSH_RD:   state_next = (pos_reg == '0) ? ret_reg : ST_PUSH_CMP;
            ST_PUSH_CMP:  state_next = push_up ? ST_PUSH_RD : ret_reg;
            ST_POP_START: state_next = (count_reg == '0) ? ST_RUN_OUT : ST_POP_TAKE;
            ST_POP_TAKE:  state_next = ST_SIFT_RD;
            ST_SIFT_RD:   state_next = l_none ? ST_NB_ADDR : ST_SIFT_CMP;
            ST_SIFT_CMP:  state_next = sift_down ? ST_SIFT_RD : ST_NB_ADDR;
            ST_NB_ADDR:   state_next = ST_NB_MUL;
            ST_NB_MUL:    state_next = inb_reg ? ST_NB_RD : ST_NB_NEXT;
            ST_NB_RD:     state_next = ST_NB_CHK;
            ST_NB_CHK:    state_next = v_rdata ? ST_NB_NEXT : ST_PUSH_START;
            ST_NB_NEXT:   state_next = (nb_reg == 3'd7) ? ST_POP_START : ST_NB_ADDR;
            default:      state_next = ST_IDLE;
        endcase
    end

    // Datapath and memory controls.
    always_comb
    begin
        ret_next       = ret_reg;
        count_next     = count_reg;
        pos_next       = pos_reg;
        item_next      = item_reg;
        top_next       = top_reg;
        raised_next    = raised_reg;
        srow_next      = srow_reg;
        scol_next      = scol_reg;
        saddr_next     = saddr_reg;
        nb_next        = nb_reg;
        px_next        = px_reg;
        pz_next        = pz_reg;
        inb_next       = inb_reg;
        naddr_next     = naddr_reg;
        rd_idx_next    = rd_idx_reg;
        rd_ok_next     = rd_ok_reg;
        out_valid_next = out_valid_reg && out_stall;
        out_h_next     = out_h_reg;
        out_idx_next   = out_idx_reg;
        out_done_next  = out_done_reg;

        h_we          = 1'b0;
        h_waddr       = cell_index[ADDR_W-1:0];
        h_wdata       = height_in;
        cell_raddr    = saddr_reg;
        f_we          = 1'b0;
        v_we          = 1'b0;
        cw_addr       = saddr_reg;
        f_wdata       = h_rdata;
        v_wdata       = 1'b0;
        f_raddr       = cell_index[ADDR_W-1:0];
        hreq.we       = 1'b0;
        hreq.waddr    = pos_reg[ADDR_W-1:0];
        hreq.wdata    = item_reg;
        hreq.raddr_a  = up_pos[ADDR_W-1:0];
        hreq.raddr_b  = lchild[ADDR_W-1:0];

        case (state_reg)
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    h_we        = (kind == KIND_WRITE) && idx_ok;
                    rd_idx_next = cell_index;
                    rd_ok_next  = idx_ok;
                    srow_next   = '0;
                    scol_next   = '0;
                    saddr_next  = '0;
                    count_next  = '0;
                end
            end
            ST_RD_OUT:
            begin
                // Keep reading the accepted cell while the result slot is busy.
                f_raddr = rd_idx_reg[ADDR_W-1:0];
                if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    out_h_next     = rd_ok_reg ? f_rdata : '0;
                    out_idx_next   = rd_idx_reg;
                    out_done_next  = 1'b0;
                end
            end
            ST_RUN_OUT:
            begin
                if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    out_h_next     = '0;
                    out_idx_next   = '0;
                    out_done_next  = 1'b1;
                end
            end
            ST_SEED_CHK:
            begin
                // Every grid cell gets its visited bit here, seeds as set.
                v_we    = 1'b1;
                v_wdata = is_seed;
                f_we    = is_seed;
                f_wdata = h_rdata;
                item_next.key = h_rdata;
                item_next.row = srow_reg;
                item_next.col = scol_reg;
                ret_next      = ST_SEED_NEXT;
            end
            ST_SEED_NEXT:
            begin
                saddr_next = saddr_reg + ADDR_W'(1);
                if (SIDE_W'(scol_reg) == side_m1)
                begin
                    scol_next = '0;
                    srow_next = srow_reg + COORD_W'(1);
                end
                else
                begin
                    scol_next = scol_reg + COORD_W'(1);
                end
            end
            ST_PUSH_START:
            begin
                if (count_reg < CNT_W'(CELLS))
                begin
                    pos_next   = count_reg;
                    count_next = count_reg + CNT_W'(1);
                end
            end
            ST_PUSH_RD:
            begin
                // At the root the new entry lands; otherwise fetch the parent.
                hreq.we = (pos_reg == '0);
            end
            ST_PUSH_CMP:
            begin
                hreq.we = 1'b1;
                if (push_up)
                begin
                    hreq.wdata = hrd_a;
                    pos_next   = up_pos;
                end
            end
            ST_POP_START:
            begin
                hreq.raddr_a = '0;
                hreq.raddr_b = ADDR_W'(count_reg - CNT_W'(1));
            end
            ST_POP_TAKE:
            begin
                top_next   = hrd_a;
                item_next  = hrd_b;
                count_next = count_reg - CNT_W'(1);
                pos_next   = '0;
                nb_next    = '0;
                if (raise_sum > $signed({1'b0, {(H_W-1){1'b1}}}))
                begin
                    raised_next = {1'b0, {(H_W-1){1'b1}}};
                end
                else
                begin
                    raised_next = raise_sum[H_W-1:0];
                end
            end
            ST_SIFT_RD:
            begin
                hreq.we      = l_none;
                hreq.raddr_a = lchild[ADDR_W-1:0];
                hreq.raddr_b = rchild[ADDR_W-1:0];
            end
            ST_SIFT_CMP:
            begin
                hreq.we = 1'b1;
                if (sift_down)
                begin
                    hreq.wdata = child;
                    pos_next   = CNT_W'(child_addr);
                end
            end
            ST_NB_ADDR:
            begin
                px_next  = px_s[COORD_W-1:0];
                pz_next  = pz_s[COORD_W-1:0];
                inb_next = (px_s >= 0) && (pz_s >= 0) &&
                           (px_s < $signed({1'b0, side_reg})) &&
                           (pz_s < $signed({1'b0, side_reg}));
            end
            ST_NB_MUL:
            begin
                naddr_next = ADDR_W'(pz_reg * side_reg + SIDE_W'(px_reg));
            end
            ST_NB_RD:
            begin
                cell_raddr = naddr_reg;
            end
            ST_NB_CHK:
            begin
                cw_addr = naddr_reg;
                if (!v_rdata)
                begin
                    v_we          = 1'b1;
                    v_wdata       = 1'b1;
                    f_we          = 1'b1;
                    f_wdata       = nb_fill;
                    item_next.key = nb_fill;
                    item_next.row = pz_reg;
                    item_next.col = px_reg;
                    ret_next      = ST_NB_NEXT;
                end
            end
            ST_NB_NEXT:
            begin
                nb_next = nb_reg + 3'd1;
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            ret_reg       <= ST_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            ret_reg       <= ret_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pos_reg     <= pos_next;
        item_reg    <= item_next;
        top_reg     <= top_next;
        raised_reg  <= raised_next;
        srow_reg    <= srow_next;
        scol_reg    <= scol_next;
        saddr_reg   <= saddr_next;
        nb_reg      <= nb_next;
        px_reg      <= px_next;
        pz_reg      <= pz_next;
        inb_reg     <= inb_next;
        naddr_reg   <= naddr_next;
        rd_idx_reg  <= rd_idx_next;
        rd_ok_reg   <= rd_ok_next;
        out_h_reg   <= out_h_next;
        out_idx_reg <= out_idx_next;
        out_done_reg <= out_done_next;
    end

endmodule
